// ===== rtl/piecewise_linear_gauge_map_unit_defines.svh =====
// assertion macros shared by the gauge map rtl
`ifndef PIECEWISE_LINEAR_GAUGE_MAP_UNIT_DEFINES_SVH
`define PIECEWISE_LINEAR_GAUGE_MAP_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define PLGM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("plgm assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define PLGM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("plgm assertion failed");

`endif

// ===== rtl/plgm_pkg.sv =====
// types, constants and the divider step shared by the gauge map modules
package plgm_pkg;

  localparam int BYTE_W       = 8;
  localparam int PAIR_COUNT_W = 4;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 64;
  localparam int TENTHS_W     = 4;
  localparam int OUT_TDATA_W  = 16;
  localparam int OUT_PAD_W    = OUT_TDATA_W - BYTE_W - TENTHS_W;
  localparam int SLOPE_W      = BYTE_W + 1;
  localparam int PROD_W       = 2 * SLOPE_W;

  // dividend and quotient of the shared restoring divider
  localparam int DIV_W     = 20;
  localparam int DIV_STEPS = 12;

  // q / 10 as (q * 6554) >> 16, exact for q below 4096
  localparam int                RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] DIV10_RECIP = 13'd6554;
  localparam int                DIV10_SHIFT = 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic {
    OP_FORWARD = 1'b0,
    OP_INVERSE = 1'b1
  } op_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TABLE_VALUES = 3'd0,
    REG_TABLE_DUTIES = 3'd1,
    REG_PAIR_COUNT   = 3'd2,
    REG_MIN_VALUE    = 3'd3,
    REG_MAX_VALUE    = 3'd4
  } reg_idx_t;

  // result = (base * span + offset * slope) / span, scaled by ten for inverse
  typedef struct packed {
    op_t                       op;
    logic [BYTE_W-1:0]         base;
    logic [BYTE_W-1:0]         span;
    logic [BYTE_W-1:0]         offset;
    logic signed [SLOPE_W-1:0] slope;
  } fr_item_t;

  // one restoring step: remainder in the top byte, quotient shifts in at the bottom
  function automatic logic [DIV_W-1:0] div_step(input logic [DIV_W-1:0] w,
                                                 input logic [BYTE_W-1:0] den);
    logic [BYTE_W:0] trial;
    logic [BYTE_W:0] diff;
    logic            ge;
    trial = w[DIV_W-1 -: BYTE_W+1];
    diff  = trial - {1'b0, den};
    ge    = (trial >= {1'b0, den});
    return {(ge ? diff[BYTE_W-1:0] : trial[BYTE_W-1:0]), w[DIV_W-BYTE_W-2:0], ge};
  endfunction

endpackage

// ===== rtl/plgm_queue.sv =====
// short request queue between the classifying front and the arithmetic back
`include "piecewise_linear_gauge_map_unit_defines.svh"

module plgm_queue import plgm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push_valid,
  output logic     push_ready,
  input  fr_item_t push_item,
  output logic     pop_valid,
  input  logic     pop_ready,
  output fr_item_t pop_item
);

  localparam int QCW = QPTR_W + 1;

  fr_item_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCW-1:0]    count;
  logic              push;
  logic              pop;

  assign push_ready = (count != QCW'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !pop) count <= count + QCW'(1);
      else if (pop && !push) count <= count - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_item;
  end

  `PLGM_ASSERT_NXT(a_q_count_up, push && !pop, count == $past(count) + QCW'(1))
  `PLGM_ASSERT_NXT(a_q_count_down, pop && !push, count == $past(count) - QCW'(1))
  `PLGM_ASSERT_IMP(a_q_ptr_match, count == '0 || count == QCW'(QUEUE_DEPTH), wr_ptr == rd_ptr)

endmodule

// ===== rtl/plgm_front.sv =====
// config registers, clamp, segment search and operand set-up for each request
module plgm_front import plgm_pkg::*; #(
  parameter int TABLE_PAIRS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [BYTE_W-1:0]      s_axis_tdata,
  input  logic                   s_axis_tuser,
  output logic                   push_valid,
  input  logic                   push_ready,
  output fr_item_t               push_item
);

  localparam int KW = $clog2(TABLE_PAIRS);
  localparam int TW = TABLE_PAIRS * BYTE_W;
  localparam logic [PAIR_COUNT_W-1:0] PAIRS_MAX = PAIR_COUNT_W'(TABLE_PAIRS);

  logic [TW-1:0]           table_values;
  logic [TW-1:0]           table_duties;
  logic [PAIR_COUNT_W-1:0] pair_count;
  logic [BYTE_W-1:0]       min_value;
  logic [BYTE_W-1:0]       max_value;

  logic [BYTE_W-1:0]       vals   [TABLE_PAIRS];
  logic [BYTE_W-1:0]       duties [TABLE_PAIRS];
  logic [PAIR_COUNT_W-1:0] n_used;
  logic [PAIR_COUNT_W-1:0] n_last;
  op_t                     op;
  logic [BYTE_W-1:0]       lo;
  logic [BYTE_W-1:0]       hi;
  logic [BYTE_W-1:0]       xc;
  logic [TABLE_PAIRS-1:0]  match;
  logic [KW-1:0]           sel;
  logic [KW-1:0]           sel_prev;
  logic                    found;
  logic [BYTE_W-1:0]       vi, vp, di, dp;
  fr_item_t                item_next;
  logic                    accept;

  // config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_values <= '0;
      table_duties <= '0;
      pair_count   <= PAIR_COUNT_W'(1);
      min_value    <= '0;
      max_value    <= '1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_TABLE_VALUES: table_values <= cfg_data[TW-1:0];
        REG_TABLE_DUTIES: table_duties <= cfg_data[TW-1:0];
        REG_PAIR_COUNT:   pair_count   <= cfg_data[PAIR_COUNT_W-1:0];
        REG_MIN_VALUE:    min_value    <= cfg_data[BYTE_W-1:0];
        REG_MAX_VALUE:    max_value    <= cfg_data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar k = 0; k < TABLE_PAIRS; k++) begin : g_pair
    assign vals[k]   = table_values[k*BYTE_W +: BYTE_W];
    assign duties[k] = table_duties[k*BYTE_W +: BYTE_W];
  end

  always_comb begin
    n_used = pair_count;
    if (pair_count == '0) n_used = PAIR_COUNT_W'(1);
    else if (pair_count > PAIRS_MAX) n_used = PAIRS_MAX;
  end

  assign n_last = n_used - PAIR_COUNT_W'(1);
  assign op     = op_t'(s_axis_tuser);

  // raise to lo first, then lower to hi
  always_comb begin
    if (op == OP_FORWARD) begin
      lo = min_value;
      hi = max_value;
    end else begin
      lo = duties[0];
      hi = duties[n_last[KW-1:0]];
    end
    xc = s_axis_tdata;
    if (xc < lo) xc = lo;
    if (xc > hi) xc = hi;
  end

  // first pair whose key is not below the clamped operand
  always_comb begin
    for (int k = 0; k < TABLE_PAIRS; k++) begin
      match[k] = (PAIR_COUNT_W'(k) < n_used) &&
                 (xc <= ((op == OP_FORWARD) ? vals[k] : duties[k]));
    end
    sel   = '0;
    found = 1'b0;
    for (int k = TABLE_PAIRS - 1; k >= 0; k--) begin
      if (match[k]) begin
        sel   = KW'(k);
        found = 1'b1;
      end
    end
  end

  assign sel_prev = sel - KW'(1);
  assign vi = vals[sel];
  assign vp = vals[sel_prev];
  assign di = duties[sel];
  assign dp = duties[sel_prev];

  // pass-through cases use a span of one and no slope
  always_comb begin
    item_next.op     = op;
    item_next.base   = '0;
    item_next.span   = BYTE_W'(1);
    item_next.offset = '0;
    item_next.slope  = '0;
    if (!found) begin
      item_next.base = (op == OP_FORWARD) ? xc : '0;
    end else if (sel == '0) begin
      item_next.base = (op == OP_FORWARD) ? di : vi;
    end else if (op == OP_FORWARD) begin
      item_next.base   = di;
      item_next.span   = vi - vp;
      item_next.offset = vi - xc;
      item_next.slope  = $signed({1'b0, dp}) - $signed({1'b0, di});
    end else begin
      item_next.base   = vp;
      item_next.span   = di - dp;
      item_next.offset = xc - dp;
      item_next.slope  = $signed({1'b0, vi}) - $signed({1'b0, vp});
    end
  end

  assign s_axis_tready = !push_valid || push_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      push_valid <= 1'b0;
    end else begin
      push_valid <= accept || (push_valid && !push_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) push_item <= item_next;
  end

endmodule

// ===== rtl/plgm_back.sv =====
// products, pipelined divider and tenths split for queued requests
`include "piecewise_linear_gauge_map_unit_defines.svh"

module plgm_back import plgm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  fr_item_t            pop_item,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [BYTE_W-1:0]   out_mapped,
  output logic [TENTHS_W-1:0] out_tenths
);

  logic adv;

  logic                     m1_valid;
  op_t                      m1_op;
  logic [2*BYTE_W-1:0]      m1_pl;
  logic signed [PROD_W-1:0] m1_ms;
  logic [BYTE_W-1:0]        m1_den;
  logic signed [PROD_W-1:0] sum;
  logic [DIV_W-1:0]         dividend_next;

  logic [DIV_STEPS:0]       st_valid;
  op_t                      st_op  [DIV_STEPS+1];
  logic [DIV_W-1:0]         st_w   [DIV_STEPS+1];
  logic [BYTE_W-1:0]        st_den [DIV_STEPS+1];

  logic [DIV_STEPS-1:0]          q;
  logic [DIV_STEPS+RECIP_W-1:0]  q_prod;
  logic                          r_valid;
  op_t                           r_op;
  logic [DIV_STEPS-1:0]          r_q;
  logic [BYTE_W-1:0]             r_qd;
  logic [DIV_STEPS-1:0]          r_rest;

  assign adv       = !m_axis_tvalid || m_axis_tready;
  assign pop_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid      <= 1'b0;
      st_valid      <= '0;
      r_valid       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m1_valid      <= pop_valid;
      st_valid      <= {st_valid[DIV_STEPS-1:0], m1_valid};
      r_valid       <= st_valid[DIV_STEPS];
      m_axis_tvalid <= r_valid;
    end
  end

  // products
  always_ff @(posedge clk) begin
    if (adv) begin
      m1_op  <= pop_item.op;
      m1_pl  <= {{BYTE_W{1'b0}}, pop_item.base} * {{BYTE_W{1'b0}}, pop_item.span};
      m1_ms  <= $signed({{(PROD_W-BYTE_W){1'b0}}, pop_item.offset}) *
                $signed({{(PROD_W-SLOPE_W){pop_item.slope[SLOPE_W-1]}}, pop_item.slope});
      m1_den <= pop_item.span;
    end
  end

  // dividend, ten times the numerator for inverse
  assign sum = $signed({{(PROD_W-2*BYTE_W){1'b0}}, m1_pl}) + m1_ms;

  always_comb begin
    if (m1_op == OP_FORWARD) begin
      dividend_next = {3'b000, sum[16:0]};
    end else begin
      dividend_next = {1'b0, sum[15:0], 3'b000} + {3'b000, sum[15:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_op[0]  <= m1_op;
      st_w[0]   <= dividend_next;
      st_den[0] <= m1_den;
    end
  end

  for (genvar i = 1; i <= DIV_STEPS; i++) begin : g_div
    always_ff @(posedge clk) begin
      if (adv) begin
        st_op[i]  <= st_op[i-1];
        st_w[i]   <= div_step(st_w[i-1], st_den[i-1]);
        st_den[i] <= st_den[i-1];
      end
    end
  end

  // quotient split into integer and tenths
  assign q      = st_w[DIV_STEPS][DIV_STEPS-1:0];
  assign q_prod = {{RECIP_W{1'b0}}, q} * {{DIV_STEPS{1'b0}}, DIV10_RECIP};

  always_ff @(posedge clk) begin
    if (adv) begin
      r_op <= st_op[DIV_STEPS];
      r_q  <= q;
      r_qd <= q_prod[DIV10_SHIFT +: BYTE_W];
    end
  end

  assign r_rest = r_q - ({1'b0, r_qd, 3'b000} + {3'b000, r_qd, 1'b0});

  always_ff @(posedge clk) begin
    if (adv) begin
      if (r_op == OP_FORWARD) begin
        out_mapped <= r_q[BYTE_W-1:0];
        out_tenths <= '0;
      end else begin
        out_mapped <= r_qd;
        out_tenths <= r_rest[TENTHS_W-1:0];
      end
    end
  end

  `PLGM_ASSERT_IMP(a_div_den_nonzero, st_valid[0], st_den[0] != '0)
  `PLGM_ASSERT_IMP(a_div_fits, st_valid[0], st_w[0][DIV_W-1 -: BYTE_W] < st_den[0])
  `PLGM_ASSERT_IMP(a_out_tenths_digit, m_axis_tvalid, out_tenths <= TENTHS_W'(9))

endmodule

// ===== rtl/piecewise_linear_gauge_map_unit.sv =====
// top level of the piecewise-linear gauge map
//
// channel   | dir | handshake                     | payload
// ----------+-----+-------------------------------+------------------------------------
// cfg       | in  | cfg_valid / cfg_ready         | cfg_index, cfg_data
// s_axis    | in  | s_axis_tvalid / s_axis_tready | tdata operand, tuser operation
// m_axis    | out | m_axis_tvalid / m_axis_tready | tdata mapped, tenths
//
// one request per cycle sustained while m_axis is not stalled, set by the 12-stage restoring divider
// path: front register, queue, products, dividend register, divider stages, tenths split, output
// a four-entry queue lets the front keep accepting while the output stalls, until the queue fills
// reset needs no clearing pass; cfg_ready is always high
module piecewise_linear_gauge_map_unit import plgm_pkg::*; #(
  parameter int TABLE_PAIRS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [BYTE_W-1:0]      s_axis_tdata,  // operand
  input  logic                   s_axis_tuser,  // operation
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata   // mapped, tenths, zero pad
);

  logic                push_valid;
  logic                push_ready;
  fr_item_t            push_item;
  logic                pop_valid;
  logic                pop_ready;
  fr_item_t            pop_item;
  logic [BYTE_W-1:0]   out_mapped;
  logic [TENTHS_W-1:0] out_tenths;

  plgm_front #(
    .TABLE_PAIRS(TABLE_PAIRS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_item     (push_item)
  );

  plgm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  plgm_back u_back (
    .clk           (clk),
    .rst           (rst),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_item      (pop_item),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .out_mapped    (out_mapped),
    .out_tenths    (out_tenths)
  );

  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_tenths, out_mapped};

endmodule

// ===== tb/sv/tb_top.sv =====
// testbench for the piecewise-linear gauge map: streamed requests checked against a predictor
module tb_top;
  import plgm_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0]   mapped;
    logic [TENTHS_W-1:0] tenths;
  } gauge_reading_t;

  typedef struct {
    logic                   is_cfg;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
    op_t                    op;
    logic [BYTE_W-1:0]      operand;
    int unsigned            gap_pct;
    int unsigned            stall_pct;
  } gauge_request_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [BYTE_W-1:0]      s_axis_tdata = '0;  // operand
  logic                   s_axis_tuser = 1'b0;  // operation
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;  // mapped, tenths, zero pad

  // shadow of the calibration registers
  logic [CFG_DATA_W-1:0]   cal_values = '0;
  logic [CFG_DATA_W-1:0]   cal_duties = '0;
  logic [PAIR_COUNT_W-1:0] cal_pairs = 4'd1;
  logic [BYTE_W-1:0]       cal_min = 8'd0;
  logic [BYTE_W-1:0]       cal_max = 8'd255;

  gauge_request_t gauge_requests[$];
  gauge_reading_t expected_readings[$];
  int unsigned    rx_stall_pct = 0;
  int unsigned    cur_gap = 0;
  int unsigned    cur_stall = 0;
  int             errors = 0;

  piecewise_linear_gauge_map_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic gauge_reading_t map_reading(op_t op, logic [BYTE_W-1:0] operand);
    gauge_reading_t r;
    int unsigned    n;
    int unsigned    k;
    logic           found;
    longint         x, lo, hi, vi, di, vp, dp, den, num, q, t;
    n = cal_pairs;
    if (n == 0) n = 1;
    if (n > 8) n = 8;
    x = operand;
    found = 1'b0;
    r.mapped = '0;
    r.tenths = '0;
    if (op == OP_FORWARD) begin
      if (x < cal_min) x = cal_min;
      if (x > cal_max) x = cal_max;
      r.mapped = x[BYTE_W-1:0];
      for (k = 0; k < n; k++) begin
        vi = cal_values[8*k +: 8];
        di = cal_duties[8*k +: 8];
        if (!found && x <= vi) begin
          found = 1'b1;
          if (k == 0) begin
            r.mapped = di[BYTE_W-1:0];
          end else begin
            vp = cal_values[8*(k-1) +: 8];
            dp = cal_duties[8*(k-1) +: 8];
            den = vp - vi;
            if (den == 0) begin
              r.mapped = dp[BYTE_W-1:0];
            end else begin
              num = (x - vi) * (dp - di) + di * den;
              q = num / den;
              r.mapped = q[BYTE_W-1:0];
            end
          end
        end
      end
    end else begin
      lo = cal_duties[7:0];
      hi = cal_duties[8*(n-1) +: 8];
      if (x < lo) x = lo;
      if (x > hi) x = hi;
      for (k = 0; k < n; k++) begin
        vi = cal_values[8*k +: 8];
        di = cal_duties[8*k +: 8];
        if (!found && x <= di) begin
          found = 1'b1;
          if (k == 0) begin
            r.mapped = vi[BYTE_W-1:0];
          end else begin
            vp = cal_values[8*(k-1) +: 8];
            dp = cal_duties[8*(k-1) +: 8];
            den = di - dp;
            if (den <= 0) begin
              r.mapped = vp[BYTE_W-1:0];
            end else begin
              num = (x - dp) * (vi - vp) + vp * den;
              if (num < 0) num = 0;
              q = num / den;
              t = ((num * 10) / den) % 10;
              r.mapped = q[BYTE_W-1:0];
              r.tenths = t[TENTHS_W-1:0];
            end
          end
        end
      end
    end
    return r;
  endfunction

  // ascending byte table, steps up to step_max, saturating at 255
  function automatic logic [CFG_DATA_W-1:0] ramp_table(int unsigned step_max);
    logic [CFG_DATA_W-1:0] r;
    int unsigned           acc;
    acc = $urandom_range(0, step_max);
    for (int k = 0; k < 8; k++) begin
      r[8*k +: 8] = (acc > 255) ? 8'd255 : acc[7:0];
      acc = acc + $urandom_range(0, step_max);
    end
    return r;
  endfunction

  task automatic push_item(op_t op, logic [BYTE_W-1:0] operand);
    gauge_request_t req;
    req.is_cfg = 1'b0;
    req.index = '0;
    req.data = '0;
    req.op = op;
    req.operand = operand;
    req.gap_pct = cur_gap;
    req.stall_pct = cur_stall;
    gauge_requests.push_back(req);
  endtask

  task automatic push_cfg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    gauge_request_t req;
    req.is_cfg = 1'b1;
    req.index = index;
    req.data = data;
    req.op = OP_FORWARD;
    req.operand = '0;
    req.gap_pct = cur_gap;
    req.stall_pct = cur_stall;
    gauge_requests.push_back(req);
  endtask

  // driver: config writes wait for an idle block, requests are predicted on acceptance
  always @(posedge clk) begin
    logic           next_sv;
    logic           next_cv;
    gauge_request_t req;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      next_sv = s_axis_tvalid;
      next_cv = cfg_valid;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_readings.push_back(map_reading(op_t'(s_axis_tuser), s_axis_tdata));
        next_sv = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TABLE_VALUES: cal_values = cfg_data;
          REG_TABLE_DUTIES: cal_duties = cfg_data;
          REG_PAIR_COUNT:   cal_pairs = cfg_data[PAIR_COUNT_W-1:0];
          REG_MIN_VALUE:    cal_min = cfg_data[BYTE_W-1:0];
          REG_MAX_VALUE:    cal_max = cfg_data[BYTE_W-1:0];
          default: ;
        endcase
        next_cv = 1'b0;
      end
      if (!next_sv && !next_cv && gauge_requests.size() != 0) begin
        req = gauge_requests[0];
        if (req.is_cfg) begin
          if (expected_readings.size() == 0 && !s_axis_tvalid) begin
            cfg_index <= req.index;
            cfg_data <= req.data;
            next_cv = 1'b1;
            void'(gauge_requests.pop_front());
          end
        end else if ($urandom_range(0, 99) >= req.gap_pct) begin
          s_axis_tdata <= req.operand;
          s_axis_tuser <= req.op;
          rx_stall_pct <= req.stall_pct;
          next_sv = 1'b1;
          void'(gauge_requests.pop_front());
        end
      end
      s_axis_tvalid <= next_sv;
      cfg_valid <= next_cv;
    end
  end

  // monitor: compare each result with the oldest prediction
  always @(posedge clk) begin
    gauge_reading_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_readings.size() == 0) begin
          $error("unexpected result: mapped %0d tenths %0d",
                 m_axis_tdata[BYTE_W-1:0], m_axis_tdata[BYTE_W +: TENTHS_W]);
          errors++;
        end else begin
          want = expected_readings.pop_front();
          if (m_axis_tdata[BYTE_W-1:0] !== want.mapped) begin
            $error("mapped: expected %0d actual %0d", want.mapped, m_axis_tdata[BYTE_W-1:0]);
            errors++;
          end
          if (m_axis_tdata[BYTE_W +: TENTHS_W] !== want.tenths) begin
            $error("tenths: expected %0d actual %0d", want.tenths,
                   m_axis_tdata[BYTE_W +: TENTHS_W]);
            errors++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] vals;
    logic [CFG_DATA_W-1:0] duts;
    logic [CFG_DATA_W-1:0] d;
    logic [CFG_DATA_W-1:0] tbl;
    logic [BYTE_W-1:0]     v;
    int unsigned           steps[4];
    op_t                   op;

    // reset table
    push_item(OP_FORWARD, 8'd0);
    push_item(OP_INVERSE, 8'd255);

    // full ascending table
    push_cfg(REG_TABLE_VALUES, 64'hFAE6_C8A0_7850_280A);
    push_cfg(REG_TABLE_DUTIES, 64'hFFDC_B48C_643C_1E05);
    push_cfg(REG_PAIR_COUNT, 64'd8);
    push_cfg(REG_MIN_VALUE, 64'd0);
    push_cfg(REG_MAX_VALUE, 64'd255);
    push_item(OP_FORWARD, 8'd0);
    push_item(OP_FORWARD, 8'd10);
    push_item(OP_FORWARD, 8'd25);
    push_item(OP_FORWARD, 8'd40);
    push_item(OP_FORWARD, 8'd251);
    push_item(OP_FORWARD, 8'd255);
    push_item(OP_INVERSE, 8'd0);
    push_item(OP_INVERSE, 8'd17);
    push_item(OP_INVERSE, 8'd100);
    push_item(OP_INVERSE, 8'd255);

    // min above max
    push_cfg(REG_MIN_VALUE, 64'd200);
    push_cfg(REG_MAX_VALUE, 64'd100);
    push_item(OP_FORWARD, 8'd0);
    push_item(OP_FORWARD, 8'd255);

    // zero-width segments, oversized pair count
    push_cfg(REG_TABLE_VALUES, 64'hFFFF_FF80_4040_0A0A);
    push_cfg(REG_TABLE_DUTIES, 64'hFFF0_9090_6020_2000);
    push_cfg(REG_PAIR_COUNT, 64'd15);
    push_cfg(REG_MIN_VALUE, 64'd0);
    push_cfg(REG_MAX_VALUE, 64'd255);
    push_item(OP_FORWARD, 8'd10);
    push_item(OP_FORWARD, 8'd64);
    push_item(OP_INVERSE, 8'h90);

    // unordered table, pair count zero then eight
    push_cfg(REG_TABLE_VALUES, 64'h0102_0304_C8A0_5020);
    push_cfg(REG_TABLE_DUTIES, 64'h1020_3040_FF80_4000);
    push_cfg(REG_PAIR_COUNT, 64'd0);
    push_item(OP_FORWARD, 8'd128);
    push_cfg(REG_PAIR_COUNT, 64'd8);
    push_item(OP_FORWARD, 8'd128);
    push_item(OP_INVERSE, 8'h50);
    push_item(OP_INVERSE, 8'hC0);

    steps = '{2, 20, 40, 70};
    for (int p = 0; p < 16; p++) begin
      case (p % 4)
        0: begin cur_gap = 0;  cur_stall = 0;  end
        1: begin cur_gap = 54; cur_stall = 0;  end
        2: begin cur_gap = 0;  cur_stall = 54; end
        default: begin cur_gap = 17; cur_stall = 17; end
      endcase
      vals = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                         : ramp_table(steps[$urandom_range(0, 3)]);
      duts = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                         : ramp_table(steps[$urandom_range(0, 3)]);
      push_cfg(REG_TABLE_VALUES, vals);
      push_cfg(REG_TABLE_DUTIES, duts);
      d = {$urandom, $urandom};
      case ($urandom_range(0, 5))
        0: d[3:0] = 4'd0;
        1: d[3:0] = 4'd1;
        2: d[3:0] = 4'd8;
        3: d[3:0] = 4'd15;
        default: d[3:0] = 4'($urandom_range(2, 8));
      endcase
      push_cfg(REG_PAIR_COUNT, d);
      d = {$urandom, $urandom};
      case ($urandom_range(0, 3))
        0: d[7:0] = 8'd0;
        1: d[7:0] = 8'd255;
        default: d[7:0] = 8'($urandom_range(0, 60));
      endcase
      push_cfg(REG_MIN_VALUE, d);
      d = {$urandom, $urandom};
      case ($urandom_range(0, 3))
        0: d[7:0] = 8'd255;
        1: d[7:0] = 8'd0;
        default: d[7:0] = 8'($urandom_range(180, 255));
      endcase
      push_cfg(REG_MAX_VALUE, d);
      if ($urandom_range(0, 3) == 0)
        push_cfg(CFG_INDEX_W'($urandom_range(REG_MAX_VALUE + 1, (1 << CFG_INDEX_W) - 1)),
                 {$urandom, $urandom});
      for (int i = 0; i < 40; i++) begin
        op = op_t'($urandom_range(0, 1));
        if ($urandom_range(0, 4) == 0) begin
          tbl = (op == OP_FORWARD) ? vals : duts;
          v = tbl[8*$urandom_range(0, 7) +: 8];
          v = 8'(v + $urandom_range(0, 2) - 1);
        end else begin
          v = 8'($urandom_range(0, 255));
        end
        push_item(op, v);
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (gauge_requests.size() != 0 || s_axis_tvalid || cfg_valid ||
           expected_readings.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0 && expected_readings.size() == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    #3000000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
